[rtl/imq_pkg.sv]
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types and constants for the IPv4 MAC masquerade switch.
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int TableEntriesDefault = 256;
  localparam int InWidth  = 296;
  localparam int OutWidth = 120;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [15:0] ArpReply  = 16'd2;
  localparam logic [15:0] LenEth    = 16'd14;
  localparam logic [15:0] LenIpv4   = 16'd34;
  localparam logic [15:0] LenArp    = 16'd42;

  localparam logic [1:0] VPass     = 2'd0;
  localparam logic [1:0] VDrop     = 2'd1;
  localparam logic [1:0] VRedirect = 2'd2;

  localparam logic CfgUplinkPort = 1'b0;
  localparam logic CfgUplinkMac  = 1'b1;

  typedef struct packed {
    logic        learn;
    logic        lookup;
    logic        is_reply;
    logic        is_arp;
    logic [31:0] addr;
    logic [15:0] port;
    logic [47:0] mac;
    logic [1:0]  verdict;
    logic [15:0] out_port;
    logic        set_src_mac;
    logic        set_arp_sender_mac;
    logic [47:0] new_src_mac;
  } job_t;

endpackage

[rtl/imq_front.sv]
// ----------------------------------------------------------------------------
// imq_front
// Classifies a frame header into a table job plus its fixed result fields.
// ----------------------------------------------------------------------------
module imq_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic [imq_pkg::InWidth-1:0] s_data,
  input  logic [15:0]             uplink_port,
  input  logic [47:0]             uplink_mac,
  output logic                    job_valid,
  input  logic                    job_ready,
  output imq_pkg::job_t           job
);
  import imq_pkg::*;

  logic        opcode;
  logic [15:0] port, len, etype, arp_op;
  logic [47:0] src_mac, sha;
  logic [31:0] ip_src, ip_dst, sip, tip;
  job_t        job_next;
  logic [1:0]  count;
  job_t        q0, q1;

  assign opcode  = s_data[0];
  assign port    = s_data[16:1];
  assign len     = s_data[32:17];
  assign etype   = s_data[48:33];
  assign src_mac = s_data[96:49];
  assign ip_src  = s_data[128:97];
  assign ip_dst  = s_data[160:129];
  assign arp_op  = s_data[176:161];
  assign sha     = s_data[224:177];
  assign sip     = s_data[256:225];
  assign tip     = s_data[288:257];

  always_comb begin
    job_next = '0;
    job_next.port = port;
    job_next.is_reply = (arp_op == ArpReply);
    if (!opcode) begin
      if (uplink_port != 16'd0 && len >= LenEth) begin
        job_next.verdict = VRedirect;
        job_next.out_port = uplink_port;
        job_next.set_src_mac = 1'b1;
        job_next.new_src_mac = uplink_mac;
        if (etype == EtypeIpv4) begin
          job_next.learn = 1'b1;
          job_next.addr = ip_src;
          job_next.mac = src_mac;
        end else if (etype == EtypeArp) begin
          job_next.learn = 1'b1;
          job_next.addr = sip;
          job_next.mac = sha;
          job_next.set_arp_sender_mac = 1'b1;
        end
        if ((etype == EtypeIpv4 && len < LenIpv4) ||
            (etype == EtypeArp && len < LenArp)) begin
          job_next = '0;
          job_next.verdict = VDrop;
        end
        if (job_next.learn && job_next.addr == 32'd0) begin
          job_next.learn = 1'b0;
        end
      end
    end else if (len >= LenEth) begin
      if (etype == EtypeIpv4 && len >= LenIpv4) begin
        job_next.lookup = 1'b1;
        job_next.addr = ip_dst;
        job_next.is_reply = 1'b1;
      end else if (etype == EtypeArp && len >= LenArp) begin
        job_next.lookup = 1'b1;
        job_next.is_arp = 1'b1;
        job_next.addr = tip;
      end
    end
  end

  // Two-entry queue toward the table engine.
  assign s_ready   = (count != 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (s_valid && s_ready && !(job_valid && job_ready)) begin
        count <= count + 2'd1;
      end else if (!(s_valid && s_ready) && job_valid && job_ready) begin
        count <= count - 2'd1;
      end
    end
    if (job_valid && job_ready) begin
      q0 <= q1;
      if (s_valid && s_ready) begin
        if (count == 2'd1) q0 <= job_next;
        else q1 <= job_next;
      end
    end else if (s_valid && s_ready) begin
      if (count == 2'd0) q0 <= job_next;
      else q1 <= job_next;
    end
  end

endmodule

[rtl/imq_back.sv]
// ----------------------------------------------------------------------------
// imq_back
// Table engine: scans the address table one entry a cycle to look up or learn.
// ----------------------------------------------------------------------------
module imq_back #(
  parameter int TableEntries = imq_pkg::TableEntriesDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  imq_pkg::job_t                job,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [imq_pkg::OutWidth-1:0] m_data
);
  import imq_pkg::*;

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EVAL = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t               state;
  job_t                 cur;
  logic [CntW-1:0]      idx;
  logic [TableEntries-1:0] valid;
  logic [31:0]          mem_addr [TableEntries];
  logic [15:0]          mem_port [TableEntries];
  logic [47:0]          mem_mac  [TableEntries];
  logic [31:0]          rd_addr;
  logic [15:0]          rd_port;
  logic [47:0]          rd_mac;
  logic                 rd_valid;
  logic [CntW-1:0]      rd_idx;
  logic                 hit, have_free;
  logic [IdxW-1:0]      hit_idx, free_idx;
  logic [15:0]          hit_port;
  logic [47:0]          hit_mac;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [OutWidth-1:0]  out_data;

  assign job_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    rd_addr <= mem_addr[idx[IdxW-1:0]];
    rd_port <= mem_port[idx[IdxW-1:0]];
    rd_mac  <= mem_mac[idx[IdxW-1:0]];
    if (wr_en) begin
      mem_addr[wr_idx] <= cur.addr;
      mem_port[wr_idx] <= cur.port;
      mem_mac[wr_idx]  <= cur.mac;
    end
  end

  always_comb begin
    wr_idx = hit ? hit_idx : free_idx;
    wr_en  = (state == S_EVAL) && cur.learn && (hit || have_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      m_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            if (job.learn || job.lookup) begin
              idx <= '0;
              rd_idx <= '0;
              hit <= 1'b0;
              have_free <= 1'b0;
              rd_valid <= 1'b0;
              state <= S_SCAN;
            end else begin
              out_data <= {2'b0, 48'd0, 1'b0, 1'b0, job.new_src_mac,
                           job.set_arp_sender_mac, job.set_src_mac,
                           job.out_port, job.verdict};
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          rd_idx   <= idx;
          rd_valid <= (idx < CntW'(TableEntries));
          if (rd_valid && valid[rd_idx[IdxW-1:0]] && rd_addr == cur.addr && !hit) begin
            hit <= 1'b1;
            hit_idx <= rd_idx[IdxW-1:0];
            hit_port <= rd_port;
            hit_mac <= rd_mac;
          end
          if (rd_valid && !valid[rd_idx[IdxW-1:0]] && !have_free) begin
            have_free <= 1'b1;
            free_idx <= rd_idx[IdxW-1:0];
          end
          if (idx == CntW'(TableEntries)) begin
            state <= S_EVAL;
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
          if (rd_valid && rd_idx == CntW'(TableEntries - 1)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (wr_en) valid[wr_idx] <= 1'b1;
          if (cur.lookup) begin
            if (hit) begin
              out_data <= {2'b0, cur.is_reply ? hit_mac : 48'd0,
                           cur.is_arp && cur.is_reply, cur.is_reply,
                           48'd0, 1'b0, 1'b0, hit_port, VRedirect};
            end else begin
              out_data <= '0;
            end
          end else begin
            out_data <= {2'b0, 48'd0, 1'b0, 1'b0, cur.new_src_mac,
                         cur.set_arp_sender_mac, cur.set_src_mac,
                         cur.out_port, cur.verdict};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid) begin
            m_valid <= 1'b1;
            m_data  <= out_data;
          end else if (m_ready) begin
            m_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/ipv4_mac_masquerade_switch.sv]
// ----------------------------------------------------------------------------
// ipv4_mac_masquerade_switch
// Verdict engine for MAC masquerading with IPv4 address learning.
//
// One beat on the slave side carries the header fields of one frame; one
// beat on the master side carries its verdict and rewrite flags. The config
// channel writes the uplink port (index 0) and uplink MAC (index 1); the user
// must do so only while the block is idle, which the block does not enforce.
// A front stage classifies each frame and queues up to two jobs; the back
// engine handles one job at a time. A lookup or learn scans the table one
// entry a cycle through the read port of the table memory. Reset clears the
// uplink registers and all entry valid bits at once. While the master side
// stalls, the result holds in its output register and the queue keeps
// accepting until it is full.
// ----------------------------------------------------------------------------
module ipv4_mac_masquerade_switch #(
  parameter int TABLE_ENTRIES = imq_pkg::TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode, ingress_port, frame_length, ethertype, eth_source_mac, ip_source,
  // ip_dest, arp_operation, arp_sender_mac, arp_sender_ip, arp_target_ip
  input  logic [imq_pkg::InWidth-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // verdict, out_port, set_src_mac, set_arp_sender_mac, new_src_mac,
  // set_dst_mac, set_arp_target_mac, new_dst_mac
  output logic [imq_pkg::OutWidth-1:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
  import imq_pkg::*;

  logic [15:0] uplink_port;
  logic [47:0] uplink_mac;
  logic        job_valid, job_ready;
  job_t        job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uplink_port <= '0;
      uplink_mac  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgUplinkPort) uplink_port <= cfg_data[15:0];
      else uplink_mac <= cfg_data;
    end
  end

  imq_front u_front (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
    .uplink_port, .uplink_mac,
    .job_valid, .job_ready, .job
  );

  imq_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
  );

endmodule

[verif/ipv4_mac_masquerade_switch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_mac_masquerade_switch_checker
// Watches the header, verdict and config channels of the masquerade switch.
// It keeps its own copy of the address table and uplink registers, works
// out the verdict of every accepted header, and compares each verdict beat
// field by field with the oldest one still pending.
// ----------------------------------------------------------------------------
module ipv4_mac_masquerade_switch_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [imq_pkg::InWidth-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [imq_pkg::OutWidth-1:0]  m_axis_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [47:0]                   cfg_data,
  output int                            pending,
  output int                            fail_count
);
  import imq_pkg::*;

  localparam int Entries = 256;

  typedef struct packed {
    logic [47:0] new_dst_mac;
    logic        set_arp_target_mac;
    logic        set_dst_mac;
    logic [47:0] new_src_mac;
    logic        set_arp_sender_mac;
    logic        set_src_mac;
    logic [15:0] out_port;
    logic [1:0]  verdict;
  } verdict_t;

  logic        host_valid [Entries];
  logic [31:0] host_addr [Entries];
  logic [15:0] host_port [Entries];
  logic [47:0] host_mac [Entries];
  logic [15:0] uplink_port;
  logic [47:0] uplink_mac;
  verdict_t    verdicts_due[$];

  assign pending = verdicts_due.size();

  function automatic int find_host(logic [31:0] addr);
    for (int i = 0; i < Entries; i++)
      if (host_valid[i] && host_addr[i] == addr) return i;
    return -1;
  endfunction

  task automatic learn_host(logic [31:0] addr, logic [15:0] port, logic [47:0] mac);
    int i;
    i = find_host(addr);
    if (addr == 0) return;
    if (i < 0) begin
      for (i = 0; i < Entries; i++)
        if (!host_valid[i]) break;
      if (i >= Entries) return;
    end else if (host_port[i] == port && host_mac[i] == mac) begin
      return;
    end
    host_valid[i] = 1'b1;
    host_addr[i] = addr;
    host_port[i] = port;
    host_mac[i] = mac;
  endtask

  task automatic predict_verdict(logic [InWidth-1:0] d);
    logic        op;
    logic [15:0] port, len, etype, arp_op;
    logic [47:0] smac, sha;
    logic [31:0] ipsrc, ipdst, sip, tip;
    logic        drop;
    int          hit;
    verdict_t    v;
    {tip, sip, sha, arp_op, ipdst, ipsrc, smac, etype, len, port, op} = d[288:0];
    v = '0;
    v.verdict = VPass;
    if (op == 1'b0) begin
      if (uplink_port != 0 && len >= LenEth) begin
        drop = 1'b0;
        if (etype == EtypeIpv4) begin
          if (len < LenIpv4) drop = 1'b1;
          else learn_host(ipsrc, port, smac);
        end else if (etype == EtypeArp) begin
          if (len < LenArp) drop = 1'b1;
          else begin
            learn_host(sip, port, sha);
            v.set_arp_sender_mac = 1'b1;
          end
        end
        if (drop) begin
          v.verdict = VDrop;
          v.set_arp_sender_mac = 1'b0;
        end else begin
          v.verdict = VRedirect;
          v.out_port = uplink_port;
          v.set_src_mac = 1'b1;
          v.new_src_mac = uplink_mac;
        end
      end
    end else if (len >= LenEth) begin
      if (etype == EtypeIpv4 && len >= LenIpv4) begin
        hit = find_host(ipdst);
        if (hit >= 0) begin
          v.verdict = VRedirect;
          v.out_port = host_port[hit];
          v.set_dst_mac = 1'b1;
          v.new_dst_mac = host_mac[hit];
        end
      end else if (etype == EtypeArp && len >= LenArp) begin
        hit = find_host(tip);
        if (hit >= 0) begin
          v.verdict = VRedirect;
          v.out_port = host_port[hit];
          if (arp_op == ArpReply) begin
            v.set_dst_mac = 1'b1;
            v.set_arp_target_mac = 1'b1;
            v.new_dst_mac = host_mac[hit];
          end
        end
      end
    end
    verdicts_due.push_back(v);
  endtask

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      for (int i = 0; i < Entries; i++) host_valid[i] = 1'b0;
      uplink_port = '0;
      uplink_mac = '0;
      verdicts_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgUplinkPort) uplink_port = cfg_data[15:0];
        else uplink_mac = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[117:0];
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected verdict beat %h", got);
        end else begin
          want = verdicts_due.pop_front();
          if (got.verdict !== want.verdict || got.out_port !== want.out_port ||
              got.set_src_mac !== want.set_src_mac ||
              got.set_arp_sender_mac !== want.set_arp_sender_mac ||
              got.new_src_mac !== want.new_src_mac ||
              got.set_dst_mac !== want.set_dst_mac ||
              got.set_arp_target_mac !== want.set_arp_target_mac ||
              got.new_dst_mac !== want.new_dst_mac) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Verdict mismatch: expected %h, got %h", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_verdict(s_axis_tdata);
    end
  end
endmodule

[verif/ipv4_mac_masquerade_switch_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_mac_masquerade_switch_tb
// Drives headers through the masquerade switch under several uplink settings:
// directed corner frames, an overfill of the table, then random learn and
// lookup traffic over a small address pool, bursty input, stalling output.
// ----------------------------------------------------------------------------
module ipv4_mac_masquerade_switch_tb;
  import imq_pkg::*;

  localparam int CycleLimit = 2000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InWidth-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutWidth-1:0]  m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [47:0]          cfg_data = '0;
  int                   pending, fail_count;
  int                   cycle_count = 0;
  logic [31:0]          addr_pool [8];

  always #5 clk = ~clk;

  ipv4_mac_masquerade_switch dut (.*);

  ipv4_mac_masquerade_switch_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    m_axis_tready <= ($urandom_range(0, 99) < 30 && cycle_count % 800 < 600) ? 1'b0 : 1'b1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [47:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_header(logic op, logic [15:0] port, logic [15:0] len,
                             logic [15:0] etype, logic [47:0] smac,
                             logic [31:0] ipsrc, logic [31:0] ipdst,
                             logic [15:0] arp_op, logic [47:0] sha,
                             logic [31:0] sip, logic [31:0] tip);
    s_axis_tdata <= {7'b0, tip, sip, sha, arp_op, ipdst, ipsrc, smac, etype, len, port, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_gap(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    return $urandom_range(0, 9) == 0 ? $urandom : addr_pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_header();
    logic [15:0] etype, len;
    int          r;
    r = $urandom_range(0, 9);
    etype = r < 4 ? EtypeIpv4 : r < 8 ? EtypeArp : 16'($urandom);
    r = $urandom_range(0, 9);
    len = r == 0 ? 16'($urandom_range(0, 13)) : r == 1 ? 16'($urandom_range(14, 41)) :
          r == 2 ? 16'($urandom) : 16'($urandom_range(42, 1518));
    send_header(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ? 16'($urandom) :
                16'($urandom_range(1, 4)), len, etype, 48'({$urandom, $urandom}),
                pick_addr(), pick_addr(),
                $urandom_range(0, 1) ? ArpReply : 16'($urandom),
                48'({$urandom, $urandom}), pick_addr(), pick_addr());
  endtask

  initial begin
    int burst;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No uplink configured: everything passes.
    send_header(1'b0, 16'd1, 16'd64, EtypeIpv4, 48'h1, 32'h0A000001, 32'h1,
                16'd1, 48'h2, 32'h3, 32'h4);
    drain();
    write_reg(CfgUplinkPort, 48'hFFFF);
    write_reg(CfgUplinkMac, 48'hFFFF_FFFF_FFFF);
    send_header(1'b0, 16'd0, 16'd13, EtypeIpv4, 48'h1, 32'h1, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd13, EtypeIpv4, 48'h1, 32'h1, 32'h1, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b0, 16'd2, 16'd33, EtypeIpv4, 48'h5, 32'h7, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b0, 16'd2, 16'd41, EtypeArp, 48'h5, 32'h0, 32'h0, 16'd2, 48'h6, 32'h8, 32'h0);
    send_header(1'b0, 16'hFFFF, 16'hFFFF, EtypeIpv4, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                32'h0, 16'hFFFF, 48'h0, 32'h0, 32'h0);
    send_header(1'b0, 16'd3, 16'd34, EtypeIpv4, 48'hA, 32'h0, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b0, 16'd4, 16'd42, EtypeArp, 48'hB, 32'h0, 32'h0, 16'd1, 48'hC, 32'h20, 32'h0);
    send_header(1'b0, 16'd4, 16'd42, EtypeArp, 48'hB, 32'h0, 32'h0, 16'd1, 48'hC, 32'h20, 32'h0);
    send_header(1'b0, 16'd5, 16'd42, EtypeArp, 48'hB, 32'h0, 32'h0, 16'd1, 48'hD, 32'h20, 32'h0);
    send_header(1'b0, 16'd5, 16'd60, 16'h86DD, 48'hE, 32'h0, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd60, EtypeIpv4, 48'h0, 32'h0, 32'hFFFF_FFFF, 16'd0, 48'h0,
                32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd60, EtypeIpv4, 48'h0, 32'h0, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd33, EtypeIpv4, 48'h0, 32'h0, 32'hFFFF_FFFF, 16'd0, 48'h0,
                32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd42, EtypeArp, 48'h0, 32'h0, 32'h0, ArpReply, 48'h0, 32'h0,
                32'h20);
    send_header(1'b1, 16'd0, 16'd42, EtypeArp, 48'h0, 32'h0, 32'h0, 16'd1, 48'h0, 32'h0, 32'h20);
    send_header(1'b1, 16'd0, 16'd41, EtypeArp, 48'h0, 32'h0, 32'h0, ArpReply, 48'h0, 32'h0,
                32'h20);
    send_header(1'b1, 16'd0, 16'd60, 16'h1234, 48'h0, 32'h0, 32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    drain();

    // Fill the table past capacity with fresh addresses.
    for (int i = 0; i < 260; i++)
      send_header(1'b0, 16'd7, 16'd64, EtypeIpv4, 48'({$urandom, $urandom}), 32'h1000 + i,
                  32'h0, 16'd0, 48'h0, 32'h0, 32'h0);
    send_header(1'b1, 16'd0, 16'd64, EtypeIpv4, 48'h0, 32'h0, 32'h1000 + 258, 16'd0, 48'h0,
                32'h0, 32'h0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      write_reg(CfgUplinkPort, phase == 2 ? 48'h0 : 48'($urandom_range(1, 65535)));
      write_reg(CfgUplinkMac, phase == 1 ? 48'h0 : 48'({$urandom, $urandom}));
      for (int n = 0; n < 40; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 40; b++, n++) random_header();
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
